### sv/mvpm_pkg.sv
// Shared types, action codes and arithmetic constants for the pan mixer.
`default_nettype none

package mvpm_pkg;

    // Action codes carried in the action field of an input transaction.
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_SET   = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_MIX   = 3'd4;

    // Clamp limits for volume and separation.
    localparam logic [6:0] VOL_MAX = 7'd127;
    localparam logic [7:0] SEP_MAX = 8'd254;

    // Output sample range.
    localparam int SMP_MAX = 32767;
    localparam int SMP_MIN = -32768;

    // Division by 127 as a multiply and shift, exact for products below 33554.
    localparam logic [15:0] DIV127_M  = 16'd33027;
    localparam int          DIV127_SH = 22;

    // Shift used by the store address reduction reciprocal.
    localparam int RECIP_SH = 32;

    // Stages between issuing a voice and its sum landing in the accumulators.
    localparam int PIPE_LAT = 4;
    localparam int DRN_W    = $clog2(PIPE_LAT);

    // One input transaction.
    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         voice;
        logic [7:0]         volume;
        logic [7:0]         separation;
        logic [15:0]        sound_address;
        logic [15:0]        sound_length;
        logic signed [15:0] sample_word;
        logic signed [15:0] music_sample;
        logic               music_on;
    } t_mix_in;

    // One result transaction.
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               frame_valid;
        logic [15:0]        active_mask;
    } t_mix_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;       // capture the accepted transaction, clear accumulators
        logic exec;      // perform load or stop
        logic gain_mul;  // form the gain products
        logic gain_wr;   // write gains, and voice setup on start
        logic mix_step;  // walk one voice through the mix pipeline
        logic res_ld;    // load the result register
    } t_ctl;

endpackage

`default_nettype wire

### sv/mvpm_ctrl.sv
// Sequencing state machine for the pan mixer.
`default_nettype none

module mvpm_ctrl #(
    parameter int VOICES = 16,
    parameter int VI_W   = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       i_action,
    output logic                  busy,
    output logic                  o_strobe,
    output mvpm_pkg::t_ctl        o_ctl,
    output logic [VI_W-1:0]       o_idx
);
    import mvpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GAIN,
        S_GWR,
        S_MIX,
        S_DRAIN,
        S_OUT
    } t_state;

    localparam logic [VI_W-1:0]  K_LAST = VI_W'(VOICES - 1);
    localparam logic [DRN_W-1:0] D_LAST = DRN_W'(PIPE_LAT - 1);

    t_state            r_state;
    logic [VI_W-1:0]   r_k;
    logic [DRN_W-1:0]  r_d;
    logic              r_strobe;
    logic              w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_idx    = r_k;

    // Commands decode directly from the state; cap also needs an accepted start.
    always_comb begin
        o_ctl          = '0;
        o_ctl.cap      = w_accept;
        o_ctl.exec     = (r_state == S_EXEC);
        o_ctl.gain_mul = (r_state == S_GAIN);
        o_ctl.gain_wr  = (r_state == S_GWR);
        o_ctl.mix_step = (r_state == S_MIX);
        o_ctl.res_ld   = (r_state == S_OUT);
    end

    // State, voice counter, drain counter and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_d      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_OUT);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_k <= '0;
                        r_d <= '0;
                        case (i_action)
                            ACT_LOAD, ACT_STOP: r_state <= S_EXEC;
                            ACT_START, ACT_SET: r_state <= S_GAIN;
                            ACT_MIX:            r_state <= S_MIX;
                            default:            r_state <= S_OUT;
                        endcase
                    end
                end
                S_EXEC: begin
                    r_state <= S_DRAIN;
                end
                S_GAIN: begin
                    r_state <= S_GWR;
                end
                S_GWR: begin
                    r_state <= S_OUT;
                end
                S_MIX: begin
                    if (r_k == K_LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_d == D_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/mvpm_dp.sv
// Datapath of the pan mixer: voice table, sample store, mix pipeline and result register.
`default_nettype none

module mvpm_dp #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536,
    parameter int VI_W         = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mvpm_pkg::t_mix_in i_cmd,
    input  wire mvpm_pkg::t_ctl    i_ctl,
    input  wire logic [VI_W-1:0]   i_idx,
    output mvpm_pkg::t_mix_out     o_result
);
    import mvpm_pkg::*;

    localparam int AW     = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int RCP_W  = 34 - AW;
    localparam int QW     = 17 - AW;
    localparam int ACC_W  = 17 + $clog2(VOICES);
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RECIP_SH) + 64'(SAMPLE_WORDS) - 64'd1) / 64'(SAMPLE_WORDS));
    localparam logic [16:0] SW17 = 17'(SAMPLE_WORDS);
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SMP_MAX);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SMP_MIN);
    localparam logic signed [16:0] S17_HI = 17'(SMP_MAX);
    localparam logic signed [16:0] S17_LO = 17'(SMP_MIN);

    // Captured transaction.
    t_mix_in r_cmd;

    // Voice table.
    logic [15:0]      r_base [VOICES];
    logic [15:0]      r_len  [VOICES];
    logic [15:0]      r_pos  [VOICES];
    logic [7:0]       r_gl   [VOICES];
    logic [7:0]       r_gr   [VOICES];
    logic [VOICES-1:0] r_act;

    // Sample store.
    logic signed [15:0] r_mem [SAMPLE_WORDS];

    // Gain computation.
    logic [14:0] r_gpl, r_gpr;
    logic [6:0]  w_vol;
    logic [7:0]  w_sep, w_lsep;
    logic [30:0] w_mgl, w_mgr;
    logic [VI_W-1:0] w_widx;
    logic        w_vok;

    // Mix pipeline.
    logic              w_hit;
    logic              r_v0, r_w0, r_v1, r_w1, r_v2, r_v3;
    logic [15:0]       r_a0, r_a1;
    logic [7:0]        r_gl0, r_gr0, r_gl1, r_gr1, r_gl2, r_gr2;
    logic [QW-1:0]     r_q1;
    logic [15+RCP_W:0] w_qp;
    logic [15:0]       w_qc;
    logic [AW-1:0]     w_addr;
    logic signed [15:0] r_sdat;
    logic signed [24:0] r_pl, r_pr;
    logic signed [24:0] w_sl, w_sr;
    logic signed [ACC_W-1:0] r_accl, r_accr;

    // Result formation.
    logic signed [15:0] w_l1, w_r1, w_l2, w_r2;
    logic signed [16:0] w_lm, w_rm;
    logic [15:0]        w_mask;
    t_mix_out           r_res;

    assign o_result = r_res;

    // Clamped volume and separation, and the voice the command addresses.
    assign w_vol  = (r_cmd.volume > 8'(VOL_MAX)) ? VOL_MAX : r_cmd.volume[6:0];
    assign w_sep  = (r_cmd.separation > SEP_MAX) ? SEP_MAX : r_cmd.separation;
    assign w_lsep = SEP_MAX - w_sep;
    assign w_widx = VI_W'(r_cmd.voice);
    assign w_vok  = (int'(r_cmd.voice) < VOICES);

    // Divide the gain products by 127.
    assign w_mgl = r_gpl * DIV127_M;
    assign w_mgr = r_gpr * DIV127_M;

    // A voice contributes when it is active and not yet at its end.
    assign w_hit = r_act[i_idx] && (r_pos[i_idx] < r_len[i_idx]);

    // Store address reduction: a16 modulo the store depth.
    assign w_qp   = r_a0 * RECIP;
    assign w_qc   = 16'(r_q1 * SW17);
    assign w_addr = AW'(r_a1 - w_qc);

    // Scale the weighted samples by 1/256 (floor).
    assign w_sl = r_pl >>> 8;
    assign w_sr = r_pr >>> 8;

    // Capture the transaction on accept.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd <= i_cmd;
        end
    end

    // Gain products ahead of the divide.
    always_ff @(posedge i_clk) begin
        if (i_ctl.gain_mul) begin
            r_gpl <= 15'(w_lsep) * 15'(w_vol);
            r_gpr <= 15'(w_sep) * 15'(w_vol);
        end
    end

    // Voice table updates: setup, gains, stop and mix stepping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else begin
            if (i_ctl.gain_wr && w_vok) begin
                r_gl[w_widx] <= w_mgl[DIV127_SH +: 8];
                r_gr[w_widx] <= w_mgr[DIV127_SH +: 8];
                if (r_cmd.action == ACT_START) begin
                    r_base[w_widx] <= r_cmd.sound_address;
                    r_len[w_widx]  <= r_cmd.sound_length;
                    r_pos[w_widx]  <= '0;
                    r_act[w_widx]  <= (r_cmd.sound_length != '0);
                end
            end
            if (i_ctl.exec && w_vok && (r_cmd.action == ACT_STOP)) begin
                r_act[w_widx] <= 1'b0;
            end
            if (i_ctl.mix_step && r_act[i_idx]) begin
                if (w_hit) begin
                    r_pos[i_idx] <= r_pos[i_idx] + 16'd1;
                end else begin
                    r_act[i_idx] <= 1'b0;
                end
            end
        end
    end

    // Pipeline valid and write marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_w0 <= 1'b0;
            r_v1 <= 1'b0;
            r_w1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_ctl.mix_step && w_hit;
            r_w0 <= i_ctl.exec && (r_cmd.action == ACT_LOAD);
            r_v1 <= r_v0;
            r_w1 <= r_w0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Pipeline payload: address, quotient, gains and products.
    always_ff @(posedge i_clk) begin
        r_a0  <= i_ctl.exec ? r_cmd.sound_address : 16'(r_base[i_idx] + r_pos[i_idx]);
        r_gl0 <= r_gl[i_idx];
        r_gr0 <= r_gr[i_idx];
        r_a1  <= r_a0;
        r_q1  <= w_qp[RECIP_SH +: QW];
        r_gl1 <= r_gl0;
        r_gr1 <= r_gr0;
        r_gl2 <= r_gl1;
        r_gr2 <= r_gr1;
        r_pl  <= r_sdat * $signed({1'b0, r_gl2});
        r_pr  <= r_sdat * $signed({1'b0, r_gr2});
    end

    // Sample store: one read per cycle, plus one write when a load reaches this stage.
    always_ff @(posedge i_clk) begin
        if (r_w1) begin
            r_mem[w_addr] <= r_cmd.sample_word;
        end
        r_sdat <= r_mem[w_addr];
    end

    // Accumulators, cleared when a transaction is accepted.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_accl <= '0;
            r_accr <= '0;
        end else if (r_v3) begin
            r_accl <= r_accl + ACC_W'(w_sl);
            r_accr <= r_accr + ACC_W'(w_sr);
        end
    end

    // Saturate the sums, add the music sample and saturate again.
    always_comb begin
        if (r_accl > ACC_HI) begin
            w_l1 = 16'(SMP_MAX);
        end else if (r_accl < ACC_LO) begin
            w_l1 = 16'(SMP_MIN);
        end else begin
            w_l1 = 16'(r_accl);
        end
        if (r_accr > ACC_HI) begin
            w_r1 = 16'(SMP_MAX);
        end else if (r_accr < ACC_LO) begin
            w_r1 = 16'(SMP_MIN);
        end else begin
            w_r1 = 16'(r_accr);
        end
        w_lm = 17'(w_l1) + 17'(r_cmd.music_sample);
        w_rm = 17'(w_r1) + 17'(r_cmd.music_sample);
        w_l2 = w_l1;
        w_r2 = w_r1;
        if (r_cmd.music_on) begin
            if (w_lm > S17_HI) begin
                w_l2 = 16'(SMP_MAX);
            end else if (w_lm < S17_LO) begin
                w_l2 = 16'(SMP_MIN);
            end else begin
                w_l2 = 16'(w_lm);
            end
            if (w_rm > S17_HI) begin
                w_r2 = 16'(SMP_MAX);
            end else if (w_rm < S17_LO) begin
                w_r2 = 16'(SMP_MIN);
            end else begin
                w_r2 = 16'(w_rm);
            end
        end
    end

    // Voice activity for the first sixteen voices.
    for (genvar g = 0; g < 16; g++) begin : g_mask
        if (g < VOICES) begin : g_on
            assign w_mask[g] = r_act[g];
        end else begin : g_off
            assign w_mask[g] = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.res_ld) begin
            r_res.active_mask <= w_mask;
            if (r_cmd.action == ACT_MIX) begin
                r_res.left_out    <= w_l2;
                r_res.right_out   <= w_r2;
                r_res.frame_valid <= 1'b1;
            end else begin
                r_res.left_out    <= '0;
                r_res.right_out   <= '0;
                r_res.frame_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/multi_voice_pan_mixer_top.sv
// Top level of the multi-voice stereo pan mixer.
// A mix transaction makes one pass of the voice table through the shared multiply pipeline,
// then waits out its four-stage drain before the result strobe.
// Start and set do the gain multiply, then divide by 127; load and stop execute, then drain.
// One transaction is in work at a time; busy is low again in the cycle that carries the strobe.
// Synchronous active-low reset stops all voices; the sample store keeps no reset value.
`default_nettype none

module multi_voice_pan_mixer_top #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mvpm_pkg::t_mix_in i_cmd,
    output logic                   o_strobe,
    output mvpm_pkg::t_mix_out     o_result
);
    import mvpm_pkg::*;

    localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_ctl            w_ctl;
    logic [VI_W-1:0] w_idx;

    // Sequencer.
    mvpm_ctrl #(
        .VOICES (VOICES),
        .VI_W   (VI_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_cmd.action),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_ctl    (w_ctl),
        .o_idx    (w_idx)
    );

    // Voice table, sample store and mixing arithmetic.
    mvpm_dp #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .VI_W         (VI_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (w_ctl),
        .i_idx    (w_idx),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the multi-voice stereo pan mixer: directed and random traffic.
`timescale 1ns / 1ps

module tb;
    import mvpm_pkg::*;

    // Action codes the block does not define; they must leave all state alone.
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam int NUM_VOICES     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_mix_in  i_cmd;
    logic     o_strobe;
    t_mix_out o_result;

    multi_voice_pan_mixer_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Predicted mixer state: sample memory with a written flag per word, and the voice table.
    logic signed [15:0] pcm_mem    [0:65535];
    bit                 pcm_loaded [0:65535];
    logic [15:0]        v_base   [NUM_VOICES];
    logic [15:0]        v_len    [NUM_VOICES];
    logic [15:0]        v_pos    [NUM_VOICES];
    logic [7:0]         v_gain_l [NUM_VOICES];
    logic [7:0]         v_gain_r [NUM_VOICES];
    bit                 v_on     [NUM_VOICES];

    t_mix_out    owed_outputs[$];
    int          err_count    = 0;
    int          gap_pct      = 0;
    int          items_sent   = 0;
    int          stall_cycles = 0;
    logic [15:0] region_base;

    function automatic int clip16(input int x);
        if (x > SMP_MAX) return SMP_MAX;
        if (x < SMP_MIN) return SMP_MIN;
        return x;
    endfunction

    // Volume and separation clamp, then left and right gain by integer division.
    function automatic void load_gains(input int v, input logic [7:0] volume,
                                       input logic [7:0] separation);
        int vol;
        int sep;
        vol = int'(volume);
        sep = int'(separation);
        if (vol > int'(VOL_MAX)) vol = int'(VOL_MAX);
        if (sep > int'(SEP_MAX)) sep = int'(SEP_MAX);
        v_gain_l[v] = 8'(((int'(SEP_MAX) - sep) * vol) / int'(VOL_MAX));
        v_gain_r[v] = 8'((sep * vol) / int'(VOL_MAX));
    endfunction

    // Applies one transaction to the predicted state and returns the result it must produce.
    function automatic t_mix_out compute_mixer_output(input t_mix_in c);
        t_mix_out    r;
        int          acc_l;
        int          acc_r;
        int          smp;
        int          mus;
        int          k;
        logic [15:0] addr;
        r = '0;
        acc_l = 0;
        acc_r = 0;
        case (c.action)
            ACT_LOAD: begin
                pcm_mem[c.sound_address]    = c.sample_word;
                pcm_loaded[c.sound_address] = 1'b1;
            end
            ACT_START: begin
                v_base[c.voice] = c.sound_address;
                v_len[c.voice]  = c.sound_length;
                v_pos[c.voice]  = '0;
                v_on[c.voice]   = (c.sound_length != '0);
                load_gains(c.voice, c.volume, c.separation);
            end
            ACT_SET: begin
                load_gains(c.voice, c.volume, c.separation);
            end
            ACT_STOP: begin
                v_on[c.voice] = 1'b0;
            end
            ACT_MIX: begin
                for (k = 0; k < NUM_VOICES; k++) begin
                    if (v_on[k]) begin
                        if (v_pos[k] >= v_len[k]) begin
                            v_on[k] = 1'b0;
                        end else begin
                            addr = v_base[k] + v_pos[k];
                            smp = {{16{pcm_mem[addr][15]}}, pcm_mem[addr]};
                            v_pos[k] = v_pos[k] + 16'd1;
                            acc_l += (smp * int'(v_gain_l[k])) >>> 8;
                            acc_r += (smp * int'(v_gain_r[k])) >>> 8;
                        end
                    end
                end
                acc_l = clip16(acc_l);
                acc_r = clip16(acc_r);
                if (c.music_on) begin
                    mus = {{16{c.music_sample[15]}}, c.music_sample};
                    acc_l = clip16(acc_l + mus);
                    acc_r = clip16(acc_r + mus);
                end
                r.left_out    = acc_l[15:0];
                r.right_out   = acc_r[15:0];
                r.frame_valid = 1'b1;
            end
            default: ;
        endcase
        for (k = 0; k < NUM_VOICES; k++) r.active_mask[k] = v_on[k];
        return r;
    endfunction

    // Fully random transaction; the builders below overwrite the fields that matter.
    function automatic t_mix_in rand_cmd();
        t_mix_in c;
        c.action        = 3'($urandom);
        c.voice         = 4'($urandom);
        c.volume        = 8'($urandom);
        c.separation    = 8'($urandom);
        c.sound_address = 16'($urandom);
        c.sound_length  = 16'($urandom);
        c.sample_word   = 16'($urandom);
        c.music_sample  = 16'($urandom);
        c.music_on      = 1'($urandom);
        return c;
    endfunction

    // Sample value biased toward full scale so that the sums saturate often.
    function automatic logic [15:0] rand_pcm();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_length();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic t_mix_in cmd_load(input logic [15:0] addr, input logic [15:0] word);
        t_mix_in c;
        c = rand_cmd();
        c.action        = ACT_LOAD;
        c.sound_address = addr;
        c.sample_word   = word;
        return c;
    endfunction

    function automatic t_mix_in cmd_start(input logic [3:0] v, input logic [15:0] addr,
                                          input logic [15:0] len, input logic [7:0] vol,
                                          input logic [7:0] sep);
        t_mix_in c;
        c = rand_cmd();
        c.action        = ACT_START;
        c.voice         = v;
        c.sound_address = addr;
        c.sound_length  = len;
        c.volume        = vol;
        c.separation    = sep;
        return c;
    endfunction

    function automatic t_mix_in cmd_set(input logic [3:0] v, input logic [7:0] vol,
                                        input logic [7:0] sep);
        t_mix_in c;
        c = rand_cmd();
        c.action     = ACT_SET;
        c.voice      = v;
        c.volume     = vol;
        c.separation = sep;
        return c;
    endfunction

    function automatic t_mix_in cmd_stop(input logic [3:0] v);
        t_mix_in c;
        c = rand_cmd();
        c.action = ACT_STOP;
        c.voice  = v;
        return c;
    endfunction

    function automatic t_mix_in cmd_mix(input logic mon, input logic [15:0] music);
        t_mix_in c;
        c = rand_cmd();
        c.action       = ACT_MIX;
        c.music_on     = mon;
        c.music_sample = music;
        return c;
    endfunction

    // Drives one transaction from a falling edge, with random gaps, until it is accepted.
    task automatic send_cmd(input t_mix_in cmd);
        bit taken;
        taken = 1'b0;
        @(negedge i_clk);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = cmd;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) taken = 1'b1;
            else @(negedge i_clk);
        end
        owed_outputs.push_back(compute_mixer_output(cmd));
        items_sent++;
    endtask

    // Before a mix, every word that a playing voice is about to read gets written.
    task automatic load_missing_sources();
        int          k;
        logic [15:0] a;
        for (k = 0; k < NUM_VOICES; k++) begin
            if (v_on[k] && v_pos[k] < v_len[k]) begin
                a = v_base[k] + v_pos[k];
                if (!pcm_loaded[a]) send_cmd(cmd_load(a, rand_pcm()));
            end
        end
    endtask

    task automatic issue(input t_mix_in c);
        if (c.action == ACT_MIX) load_missing_sources();
        send_cmd(c);
    endtask

    // Frames with no voice playing: silence, then the music sample alone.
    task automatic test_silent_frames();
        issue(cmd_mix(1'b0, 16'hFFFF));
        issue(cmd_mix(1'b1, 16'h8000));
    endtask

    // Voices that run across the top of the address space, clamped gains,
    // a zero-length start and a gain update on an idle voice.
    task automatic test_address_wrap_and_clamps();
        issue(cmd_load(16'hFFFE, 16'h7FFF));
        issue(cmd_load(16'hFFFF, 16'h8000));
        issue(cmd_load(16'h0000, 16'h1234));
        issue(cmd_load(16'h0001, 16'hFFFF));
        issue(cmd_start(4'd0, 16'hFFFE, 16'd4, 8'hFF, 8'h00));
        issue(cmd_start(4'd15, 16'hFFFF, 16'd2, 8'd127, 8'hFF));
        issue(cmd_start(4'd3, 16'h0000, 16'd0, 8'd64, 8'd128));
        issue(cmd_set(4'd5, 8'hFF, 8'hFF));
        issue(cmd_mix(1'b0, 16'h0000));
        issue(cmd_mix(1'b1, 16'h0001));
    endtask

    // Several full-scale voices push the left sum past the limits, and the music drives both sums into saturation.
    task automatic test_saturation();
        issue(cmd_start(4'd1, 16'hFFFE, 16'd2, 8'hFF, 8'h00));
        issue(cmd_start(4'd2, 16'hFFFE, 16'd2, 8'd200, 8'h01));
        issue(cmd_start(4'd4, 16'hFFFE, 16'd2, 8'd127, 8'hFE));
        issue(cmd_mix(1'b1, 16'h7FFF));
        issue(cmd_mix(1'b1, 16'h8000));
    endtask

    // Voices that reach their end, explicit stops, a long sound and the reserved actions.
    task automatic test_end_stop_and_reserved();
        t_mix_in c;
        issue(cmd_set(4'd0, 8'd0, 8'd128));
        issue(cmd_mix(1'b0, 16'h0000));
        issue(cmd_stop(4'd15));
        issue(cmd_stop(4'd9));
        issue(cmd_start(4'd6, 16'h0000, 16'hFFFF, 8'd127, 8'd128));
        issue(cmd_mix(1'b0, 16'h0000));
        issue(cmd_stop(4'd6));
        c = rand_cmd();
        c.action = ACT_RSVD5;
        issue(c);
        c = rand_cmd();
        c.action = ACT_RSVD6;
        issue(c);
        c = '1;
        c.action = ACT_RSVD7;
        issue(c);
    endtask

    // Mostly well-formed play sequences with random content, plus some noise.
    task automatic test_random_traffic(input int count, input int idle_pct);
        int          stop_at;
        int          pick;
        logic [15:0] a;
        t_mix_in     c;
        gap_pct = idle_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                a = $urandom_range(1) ? region_base + 16'($urandom_range(63)) : 16'($urandom);
                issue(cmd_load(a, rand_pcm()));
            end else if (pick < 25) begin
                if ($urandom_range(7) == 0) region_base = 16'($urandom);
                issue(cmd_start(4'($urandom), region_base + 16'($urandom_range(63)),
                                rand_length(), 8'($urandom), 8'($urandom)));
            end else if (pick < 33) begin
                issue(cmd_set(4'($urandom), 8'($urandom), 8'($urandom)));
            end else if (pick < 40) begin
                issue(cmd_stop(4'($urandom)));
            end else if (pick < 43) begin
                c = rand_cmd();
                c.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
                issue(c);
            end else begin
                issue(cmd_mix(1'($urandom), $urandom_range(3) == 0 ? rand_pcm()
                                                                   : 16'($urandom)));
            end
        end
    endtask

    // Compare each result with the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_results
        t_mix_out want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (owed_outputs.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                err_count++;
            end else begin
                want = owed_outputs.pop_front();
                if (o_result.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, actual %0d", want.left_out,
                           o_result.left_out);
                    err_count++;
                end
                if (o_result.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, actual %0d", want.right_out,
                           o_result.right_out);
                    err_count++;
                end
                if (o_result.frame_valid !== want.frame_valid) begin
                    $error("frame_valid: expected %0b, actual %0b", want.frame_valid,
                           o_result.frame_valid);
                    err_count++;
                end
                if (o_result.active_mask !== want.active_mask) begin
                    $error("active_mask: expected %h, actual %h", want.active_mask,
                           o_result.active_mask);
                    err_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        region_base = 16'($urandom);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_silent_frames();
        test_address_wrap_and_clamps();
        test_saturation();
        test_end_stop_and_reserved();
        test_random_traffic(400, 28);
        test_random_traffic(400, 52);
        test_random_traffic(400, 0);

        @(negedge i_clk);
        start = 1'b0;
        while (owed_outputs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
